// File: sv/osa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_pkg: shared definitions for the object slot allocator
// Field widths, command and register codes, reset values and the slot
// memory write control word.
// ----------------------------------------------------------------------------
package osa_pkg;

    // Field widths
    localparam int KIND_W      = 2;
    localparam int INDEX_W     = 10;
    localparam int HANDLE_W    = 32;
    localparam int LIMIT_W     = 11;
    localparam int COST_W      = 8;
    localparam int THRESH_W    = 18;
    localparam int TOTAL_W     = 18;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 18;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_STORE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TENURE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECT_COST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GC_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [LIMIT_W-1:0]  CELL_LIMIT_RST   = 11'd1024;
    localparam logic [COST_W-1:0]   OBJECT_COST_RST  = 8'd1;
    localparam logic [THRESH_W-1:0] GC_THRESHOLD_RST = 18'd682;

    // Slot memory write control
    typedef struct packed {
        logic we;         // write this cycle
        logic valid_bit;  // 1: occupy slot and store handle, 0: release slot
    } slot_wr_t;

endpackage : osa_pkg
`default_nettype wire

// File: sv/osa_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_slot_store: slot handle and occupancy memories
// One write port and one registered read port. Occupancy entries are only
// meaningful below the fresh-id mark; every such entry has been written.
// ----------------------------------------------------------------------------
module osa_slot_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int HW    = 32
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [HW-1:0]     rd_handle,
    output logic                   rd_valid,
    input  wire osa_pkg::slot_wr_t wr,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [HW-1:0]     wr_handle
);
    import osa_pkg::*;

    logic [HW-1:0] handle_mem [DEPTH];
    logic          valid_mem  [DEPTH];

    // Write port: handle written only when a slot is occupied
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            valid_mem[wr_addr] <= wr.valid_bit;
            if (wr.valid_bit)
            begin
                handle_mem[wr_addr] <= wr_handle;
            end
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_handle <= handle_mem[rd_addr];
            rd_valid  <= valid_mem[rd_addr];
        end
    end

endmodule : osa_slot_store
`default_nettype wire

// File: sv/osa_free_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osa_free_stack: LIFO storage of released slot ids
// The stack pointer lives in the controller; this holds the entries with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module osa_free_stack #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [AW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [AW-1:0] wr_data
);
    import osa_pkg::*;

    logic [AW-1:0] stack_mem [DEPTH];

    // Push
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
    end

    // Top-of-stack read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= stack_mem[rd_addr];
        end
    end

endmodule : osa_free_stack
`default_nettype wire

// File: sv/object_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// object_slot_allocator: slot id allocator for an object heap
// Store/erase/get/tenure commands over a slot memory with a LIFO free list.
// ----------------------------------------------------------------------------
// Each command runs as a transfer and a step: the transfer edge registers the
// command and launches the reads of the slot memory and the top of the free
// stack; the step edge, taken once the result register is free, updates state,
// writes the memories and loads the result register. The input is ready again
// in the cycle after the step, so a new command waits until the last one is
// stepped; a stalled result holds only the command behind it. Slot occupancy
// needs no clearing after reset: entries at or above the fresh-id mark read as
// empty and every entry below it has been written. Configuration writes are
// always taken and must be made while no command is in flight.
module object_slot_allocator #(
    parameter int CAPACITY    = 1024,
    parameter int HANDLE_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Command stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [osa_pkg::S_TDATA_W-1:0]       s_tdata,  // [9:0] slot_index,
                                                               // [41:10] object_handle
    input  wire logic [osa_pkg::KIND_W-1:0]          s_tuser,  // [1:0] kind
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [osa_pkg::M_TDATA_W-1:0]       m_tdata,  // [9:0] result_index,
                                                               // [10] success,
                                                               // [42:11] handle_out,
                                                               // [43] collect_due
    // Configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [osa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [osa_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import osa_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
    localparam int XW = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int MW = (CW > INDEX_W) ? CW : INDEX_W;

    // Configuration registers
    logic [LIMIT_W-1:0]  cell_limit_reg;
    logic [COST_W-1:0]   object_cost_reg;
    logic [THRESH_W-1:0] gc_threshold_reg;

    // Allocator state
    logic [CW-1:0]      free_count_reg,  free_count_next;
    logic [CW-1:0]      fresh_mark_reg,  fresh_mark_next;
    logic [CW-1:0]      tenure_mark_reg, tenure_mark_next;
    logic [TOTAL_W-1:0] total_cost_reg,  total_cost_next;

    // Command register
    logic                busy_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [HW-1:0]       handle_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Transfer and step enables
    logic in_fire;
    logic do_step;

    // Memory ports
    logic [XW-1:0]  idx_in_x;
    logic [AW-1:0]  slot_rd_addr;
    logic [CW-1:0]  pop_cnt;
    logic [AW-1:0]  pop_addr;
    logic [HW-1:0]  rd_handle;
    logic           rd_valid;
    logic [AW-1:0]  pop_id;
    slot_wr_t       slot_wr;
    logic [AW-1:0]  slot_wr_addr;
    logic           push_en;
    logic [AW-1:0]  push_addr;

    // Step datapath
    logic [XW-1:0]      idx_x;
    logic [AW-1:0]      idx_addr;
    logic [MW-1:0]      idx_m, fresh_m, tenure_m;
    logic               idx_in_cap;
    logic               fc_nz;
    logic               fresh_ok;
    logic               stack_room;
    logic [AW-1:0]      store_id;
    logic [XW-1:0]      store_id_x;
    logic [TOTAL_W:0]   cost_sum;
    logic [INDEX_W-1:0] res_idx;
    logic               ok;
    logic [HANDLE_W-1:0] hout;
    logic               collect;

    assign s_tready  = !busy_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign do_step   = busy_reg && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Read addresses launched at the command transfer
    assign idx_in_x     = XW'(s_tdata[INDEX_W-1:0]);
    assign slot_rd_addr = idx_in_x[AW-1:0];
    assign pop_cnt      = free_count_reg - CW'(1);
    assign pop_addr     = pop_cnt[AW-1:0];

    osa_slot_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .HW    (HW)
    ) u_slot_store (
        .clk       (clk),
        .rd_en     (in_fire),
        .rd_addr   (slot_rd_addr),
        .rd_handle (rd_handle),
        .rd_valid  (rd_valid),
        .wr        (slot_wr),
        .wr_addr   (slot_wr_addr),
        .wr_handle (handle_reg)
    );

    osa_free_stack #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_free_stack (
        .clk     (clk),
        .rd_en   (in_fire),
        .rd_addr (pop_addr),
        .rd_data (pop_id),
        .wr_en   (push_en),
        .wr_addr (push_addr),
        .wr_data (idx_addr)
    );

    // Range checks on the registered command
    assign idx_x      = XW'(idx_reg);
    assign idx_addr   = idx_x[AW-1:0];
    assign idx_m      = MW'(idx_reg);
    assign fresh_m    = MW'(fresh_mark_reg);
    assign tenure_m   = MW'(tenure_mark_reg);
    assign idx_in_cap = 32'(idx_reg) < 32'(CAPACITY);
    assign fc_nz      = free_count_reg != '0;
    assign fresh_ok   = (32'(fresh_mark_reg) < 32'(CAPACITY))
                        && (LW'(fresh_mark_reg) < LW'(cell_limit_reg));
    assign stack_room = 32'(free_count_reg) < 32'(CAPACITY);
    assign store_id   = fc_nz ? pop_id : fresh_mark_reg[AW-1:0];
    assign store_id_x = XW'(store_id);
    assign cost_sum   = {1'b0, total_cost_reg} + (TOTAL_W+1)'(object_cost_reg);
    assign push_addr  = free_count_reg[AW-1:0];

    // Command execution
    always_comb
    begin
        free_count_next  = free_count_reg;
        fresh_mark_next  = fresh_mark_reg;
        tenure_mark_next = tenure_mark_reg;
        total_cost_next  = total_cost_reg;
        slot_wr          = '0;
        slot_wr_addr     = idx_addr;
        push_en          = 1'b0;
        res_idx          = idx_reg;
        ok               = 1'b0;
        hout             = '0;
        case (kind_reg)
            KIND_STORE:
            begin
                if (fc_nz || fresh_ok)
                begin
                    if (fc_nz)
                    begin
                        free_count_next = pop_cnt;
                    end
                    else
                    begin
                        fresh_mark_next = fresh_mark_reg + CW'(1);
                    end
                    slot_wr.we        = do_step;
                    slot_wr.valid_bit = 1'b1;
                    slot_wr_addr      = store_id;
                    total_cost_next   = cost_sum[TOTAL_W] ? '1 : cost_sum[TOTAL_W-1:0];
                    res_idx           = store_id_x[INDEX_W-1:0];
                    ok                = 1'b1;
                end
            end
            KIND_ERASE:
            begin
                if (idx_in_cap && (idx_m >= tenure_m) && (idx_m < fresh_m)
                    && rd_valid && stack_room)
                begin
                    slot_wr.we        = do_step;
                    slot_wr.valid_bit = 1'b0;
                    push_en           = do_step;
                    free_count_next   = free_count_reg + CW'(1);
                    total_cost_next   = (total_cost_reg > TOTAL_W'(object_cost_reg))
                                        ? total_cost_reg - TOTAL_W'(object_cost_reg)
                                        : '0;
                    ok                = 1'b1;
                end
            end
            KIND_GET:
            begin
                if (idx_in_cap && (idx_m < fresh_m) && rd_valid)
                begin
                    hout = HANDLE_W'(rd_handle);
                    ok   = 1'b1;
                end
            end
            KIND_TENURE:
            begin
                tenure_mark_next = fresh_mark_reg;
                ok               = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        collect      = total_cost_next > gc_threshold_reg;
        m_tdata_next = M_TDATA_W'({collect, hout, ok, res_idx});
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_limit_reg   <= CELL_LIMIT_RST;
            object_cost_reg  <= OBJECT_COST_RST;
            gc_threshold_reg <= GC_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CELL_LIMIT:   cell_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_OBJECT_COST:  object_cost_reg  <= cfg_data[COST_W-1:0];
                CFG_GC_THRESHOLD: gc_threshold_reg <= cfg_data[THRESH_W-1:0];
                default:          cell_limit_reg   <= cell_limit_reg;
            endcase
        end
    end

    // Allocator state and control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg  <= '0;
            fresh_mark_reg  <= '0;
            tenure_mark_reg <= '0;
            total_cost_reg  <= '0;
            busy_reg        <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (do_step)
            begin
                free_count_reg  <= free_count_next;
                fresh_mark_reg  <= fresh_mark_next;
                tenure_mark_reg <= tenure_mark_next;
                total_cost_reg  <= total_cost_next;
            end
            if (in_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (do_step)
            begin
                busy_reg <= 1'b0;
            end
            if (do_step)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg   <= s_tuser;
            idx_reg    <= s_tdata[INDEX_W-1:0];
            handle_reg <= s_tdata[INDEX_W +: HW];
        end
        if (do_step)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule : object_slot_allocator
`default_nettype wire
